// ===== hdl/one_euro_quaternion_smoother_macros.svh =====
// Assertion helpers shared by the smoother RTL.
`ifndef ONE_EURO_QUATERNION_SMOOTHER_MACROS_SVH
`define ONE_EURO_QUATERNION_SMOOTHER_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define OEQS_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("oeqs: check failed");
// next-cycle implication
`define OEQS_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("oeqs: check failed");
`else
`define OEQS_ASSERT_NOW(lbl, clk, rstn, ante, cons)
`define OEQS_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

// ===== hdl/oeqs_pkg.sv =====
package oeqs_pkg;

    localparam int CHANNELS      = 4;
    localparam int COMP_BITS_DEF = 16;
    localparam int RATE_BITS     = 16;
    localparam int RATE_AXES     = 3;
    // narrowest shared multiplier operand: cut * 2pi needs 16 x 19 bits unsigned
    localparam int MUL_MIN_W     = 20;

    localparam logic [18:0] TWO_PI_Q16 = 19'd411775;

    localparam int APB_AW = 4;
    localparam int APB_DW = 32;

    localparam logic [9:0]  RST_SAMPLE_RATE = 10'd90;
    localparam logic [15:0] RST_MIN_CUTOFF  = 16'd256;
    localparam logic [15:0] RST_BETA_GAIN   = 16'd0;

    typedef enum logic [1:0] {
        REG_SAMPLE_RATE = 2'd0,
        REG_MIN_CUTOFF  = 2'd1,
        REG_BETA_GAIN   = 2'd2
    } t_reg_idx;

endpackage

// ===== hdl/oeqs_mul.sv =====
// Shared signed multiplier, product registered.
module oeqs_mul #(
    parameter int W = oeqs_pkg::MUL_MIN_W
) (
    input  logic                  i_clk,
    input  logic signed [W-1:0]   i_a,
    input  logic signed [W-1:0]   i_b,
    output logic signed [2*W-1:0] o_p
);

    logic signed [2*W-1:0] r_p;

    always_ff @(posedge i_clk) begin
        r_p <= i_a * i_b;
    end

    assign o_p = r_p;

endmodule

// ===== hdl/one_euro_quaternion_smoother.sv =====
// Channel   Dir  Handshake                     Payload
// s_axis    in   s_axis_tvalid/s_axis_tready   quaternion x,y,z,w + angular rate x,y,z
// m_axis    out  m_axis_tvalid/m_axis_tready   smoothed quaternion x,y,z,w
// apb       in   psel/penable/pwrite/pready    sample_rate_hz, min_cutoff, beta_gain
//
// Flow: one beat at a time; s_axis_tready is high only while the sequencer idles.
// A primed beat runs from accept to result load through distance, flip, rate squares,
// square root, cutoff/alpha setup, divide, blend and load. The first beat after reset
// goes from flip straight to load. All products go through oeqs_mul.
// Reset (synchronous, active low) restores the identity quaternion and config registers.
// A waiting result never blocks accept; only the final load step stalls on m_axis.
`include "one_euro_quaternion_smoother_macros.svh"

module one_euro_quaternion_smoother #(
    parameter int COMP_BITS = oeqs_pkg::COMP_BITS_DEF,
    localparam int IN_W  = ((4 * COMP_BITS + 3 * oeqs_pkg::RATE_BITS + 7) / 8) * 8,
    localparam int OUT_W = ((4 * COMP_BITS + 7) / 8) * 8
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    // quat_x, quat_y, quat_z, quat_w, rate_x, rate_y, rate_z (low bits first)
    input  logic [IN_W-1:0]             s_axis_tdata,
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    // out_x, out_y, out_z, out_w (low bits first)
    output logic [OUT_W-1:0]            m_axis_tdata,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [oeqs_pkg::APB_AW-1:0] paddr,
    input  logic [oeqs_pkg::APB_DW-1:0] pwdata,
    output logic [oeqs_pkg::APB_DW-1:0] prdata,
    output logic                        pready
);

    localparam int NCH = oeqs_pkg::CHANNELS;
    localparam int NAX = oeqs_pkg::RATE_AXES;
    localparam int RB  = oeqs_pkg::RATE_BITS;
    localparam int MW  = (COMP_BITS + 1 > oeqs_pkg::MUL_MIN_W) ?
                         COMP_BITS + 1 : oeqs_pkg::MUL_MIN_W;
    localparam int PW  = 2 * MW;
    localparam int DACC_W = 2 * COMP_BITS + 3;
    localparam logic [DACC_W-1:0] DIST_TH =
        {{(DACC_W-1){1'b0}}, 1'b1} << (2 * COMP_BITS - 1);
    localparam logic signed [COMP_BITS-1:0] COMP_MIN = {1'b1, {(COMP_BITS-1){1'b0}}};
    localparam logic signed [COMP_BITS-1:0] COMP_MAX = {1'b0, {(COMP_BITS-1){1'b1}}};

    typedef enum logic [3:0] {
        S_IDLE, S_DIST, S_FLIP, S_RATE, S_SQRT, S_BETA, S_NUM,
        S_DEN, S_DINIT, S_DIV, S_BLEND, S_OUT
    } t_state;

    t_state      r_state;
    logic [4:0]  r_idx;
    logic        r_primed;
    logic        r_ovld;

    logic [9:0]  r_rate_hz;
    logic [15:0] r_min_cut;
    logic [15:0] r_beta;

    // datapath
    logic signed [COMP_BITS-1:0] r_q   [NCH];   // input, rotates while in use
    logic signed [COMP_BITS-1:0] r_sq  [NCH];   // stored output, rotates with r_q
    logic signed [COMP_BITS-1:0] r_out [NCH];
    logic signed [RB-1:0]        r_rate [NAX];
    logic [DACC_W-1:0] r_dacc;
    logic [31:0]       r_racc;
    logic [31:0]       r_rad;
    logic [16:0]       r_srem;
    logic [15:0]       r_mag;
    logic [15:0]       r_cut;
    logic [34:0]       r_num;
    logic [35:0]       r_den;
    logic [35:0]       r_drem;
    logic [16:0]       r_nlo;
    logic [16:0]       r_quot;

    logic signed [MW-1:0] mul_a;
    logic signed [MW-1:0] mul_b;
    logic signed [PW-1:0] mul_p;

    oeqs_mul #(.W(MW)) u_mul (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (mul_p)
    );

    logic s_acc, m_acc, cfg_wr, out_load;
    assign s_axis_tready = (r_state == S_IDLE);
    assign s_acc    = s_axis_tvalid && s_axis_tready;
    assign m_acc    = r_ovld && m_axis_tready;
    assign cfg_wr   = psel && penable && pwrite;
    assign out_load = (r_state == S_OUT) && (!r_ovld || m_axis_tready);

    // element-0 differences
    logic signed [COMP_BITS:0] dist_d;   // s - q
    logic signed [COMP_BITS:0] blend_d;  // q - s
    assign dist_d  = {r_sq[0][COMP_BITS-1], r_sq[0]} - {r_q[0][COMP_BITS-1], r_q[0]};
    assign blend_d = {r_q[0][COMP_BITS-1], r_q[0]} - {r_sq[0][COMP_BITS-1], r_sq[0]};

    // shared multiplier operand select
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            S_DIST: begin
                mul_a = MW'(dist_d);
                mul_b = MW'(dist_d);
            end
            S_RATE: begin
                mul_a = MW'(r_rate[0]);
                mul_b = MW'(r_rate[0]);
            end
            S_BETA: begin
                mul_a = MW'($signed({1'b0, r_beta}));
                mul_b = MW'($signed({1'b0, r_mag}));
            end
            S_NUM: begin
                mul_a = MW'($signed({1'b0, r_cut}));
                mul_b = MW'($signed({1'b0, oeqs_pkg::TWO_PI_Q16}));
            end
            S_BLEND: begin
                mul_a = MW'($signed({1'b0, r_quot}));
                mul_b = MW'(blend_d);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // antipodal flip
    logic flip;
    logic signed [COMP_BITS-1:0] q_neg [NCH];
    assign flip = (r_dacc > DIST_TH);
    always_comb begin
        for (int i = 0; i < NCH; i++) begin
            if (!flip) q_neg[i] = r_q[i];
            else if (r_q[i] == COMP_MIN) q_neg[i] = COMP_MAX;
            else q_neg[i] = -r_q[i];
        end
    end

    // square root step, two radicand bits per cycle
    logic [18:0] sq_sh, sq_trial;
    logic        sq_ge;
    assign sq_sh    = {r_srem, r_rad[31:30]};
    assign sq_trial = {1'b0, r_mag, 2'b01};
    assign sq_ge    = (sq_sh >= sq_trial);

    // cutoff with saturation
    logic [24:0] cut_sum;
    assign cut_sum = {9'd0, r_min_cut} + 25'(mul_p[32:8]);

    logic [9:0] freq;
    assign freq = (r_rate_hz == '0) ? 10'd1 : r_rate_hz;

    logic [51:0] numer;
    assign numer = {r_num, 16'd0} + 52'(r_den >> 1);

    // restoring divide step
    logic [36:0] dv_sh;
    logic        dv_ge;
    assign dv_sh = {r_drem, r_nlo[16]};
    assign dv_ge = (dv_sh >= {1'b0, r_den});

    // blend: s + round(alpha * (q - s) / 2^16), half up
    logic signed [PW:0] bl_rnd;
    logic signed [COMP_BITS-1:0] bl_new;
    assign bl_rnd = ($signed({mul_p[PW-1], mul_p}) + (PW+1)'(32768)) >>> 16;
    assign bl_new = r_sq[0] + COMP_BITS'(bl_rnd);

    // control and stored state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_idx     <= '0;
            r_primed  <= 1'b0;
            r_ovld    <= 1'b0;
            r_rate_hz <= oeqs_pkg::RST_SAMPLE_RATE;
            r_min_cut <= oeqs_pkg::RST_MIN_CUTOFF;
            r_beta    <= oeqs_pkg::RST_BETA_GAIN;
            for (int i = 0; i < NCH - 1; i++) r_sq[i] <= '0;
            r_sq[NCH-1] <= COMP_MAX;
        end else begin
            if (cfg_wr) begin
                unique case (paddr[3:2])
                    oeqs_pkg::REG_SAMPLE_RATE: r_rate_hz <= pwdata[9:0];
                    oeqs_pkg::REG_MIN_CUTOFF:  r_min_cut <= pwdata[15:0];
                    oeqs_pkg::REG_BETA_GAIN:   r_beta    <= pwdata[15:0];
                    default: ;
                endcase
            end
            if (m_acc && !out_load) r_ovld <= 1'b0;

            unique case (r_state)
                S_IDLE: begin
                    if (s_acc) begin
                        r_state <= S_DIST;
                        r_idx   <= '0;
                    end
                end
                S_DIST: begin
                    if (r_idx < 5'(NCH)) begin
                        for (int i = 0; i < NCH - 1; i++) r_sq[i] <= r_sq[i+1];
                        r_sq[NCH-1] <= r_sq[0];
                    end
                    if (r_idx == 5'(NCH)) begin
                        r_state <= S_FLIP;
                        r_idx   <= '0;
                    end else begin
                        r_idx <= r_idx + 5'd1;
                    end
                end
                S_FLIP: begin
                    if (!r_primed) begin
                        for (int i = 0; i < NCH; i++) r_sq[i] <= q_neg[i];
                        r_primed <= 1'b1;
                        r_state  <= S_OUT;
                    end else begin
                        r_state <= S_RATE;
                    end
                end
                S_RATE: begin
                    if (r_idx == 5'(NAX)) begin
                        r_state <= S_SQRT;
                        r_idx   <= '0;
                    end else begin
                        r_idx <= r_idx + 5'd1;
                    end
                end
                S_SQRT: begin
                    if (r_idx == 5'd15) begin
                        r_state <= S_BETA;
                        r_idx   <= '0;
                    end else begin
                        r_idx <= r_idx + 5'd1;
                    end
                end
                S_BETA: begin
                    if (r_idx == 5'd1) begin
                        r_state <= S_NUM;
                        r_idx   <= '0;
                    end else begin
                        r_idx <= r_idx + 5'd1;
                    end
                end
                S_NUM: begin
                    if (r_idx == 5'd1) begin
                        r_state <= S_DEN;
                        r_idx   <= '0;
                    end else begin
                        r_idx <= r_idx + 5'd1;
                    end
                end
                S_DEN:   r_state <= S_DINIT;
                S_DINIT: begin
                    r_state <= S_DIV;
                    r_idx   <= '0;
                end
                S_DIV: begin
                    if (r_idx == 5'd16) begin
                        r_state <= S_BLEND;
                        r_idx   <= '0;
                    end else begin
                        r_idx <= r_idx + 5'd1;
                    end
                end
                S_BLEND: begin
                    // odd cycle: product of element 0 is ready, write and rotate
                    if (r_idx[0]) begin
                        for (int i = 0; i < NCH - 1; i++) r_sq[i] <= r_sq[i+1];
                        r_sq[NCH-1] <= bl_new;
                    end
                    if (r_idx == 5'(2 * NCH - 1)) begin
                        r_state <= S_OUT;
                        r_idx   <= '0;
                    end else begin
                        r_idx <= r_idx + 5'd1;
                    end
                end
                S_OUT: begin
                    if (out_load) begin
                        r_ovld  <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (s_acc) begin
                    for (int i = 0; i < NCH; i++)
                        r_q[i] <= s_axis_tdata[i*COMP_BITS +: COMP_BITS];
                    for (int j = 0; j < NAX; j++)
                        r_rate[j] <= s_axis_tdata[NCH*COMP_BITS + j*RB +: RB];
                    r_dacc <= '0;
                    r_racc <= '0;
                end
            end
            S_DIST: begin
                if (r_idx < 5'(NCH)) begin
                    for (int i = 0; i < NCH - 1; i++) r_q[i] <= r_q[i+1];
                    r_q[NCH-1] <= r_q[0];
                end
                if (r_idx != 5'd0) r_dacc <= r_dacc + DACC_W'($unsigned(mul_p));
            end
            S_FLIP: begin
                for (int i = 0; i < NCH; i++) r_q[i] <= q_neg[i];
            end
            S_RATE: begin
                if (r_idx < 5'(NAX)) begin
                    for (int j = 0; j < NAX - 1; j++) r_rate[j] <= r_rate[j+1];
                    r_rate[NAX-1] <= r_rate[0];
                end
                if (r_idx != 5'd0) r_racc <= r_racc + 32'($unsigned(mul_p));
                if (r_idx == 5'(NAX)) begin
                    r_rad  <= r_racc + 32'($unsigned(mul_p));
                    r_srem <= '0;
                    r_mag  <= '0;
                end
            end
            S_SQRT: begin
                r_rad  <= r_rad << 2;
                r_srem <= sq_ge ? 17'(sq_sh - sq_trial) : 17'(sq_sh);
                r_mag  <= {r_mag[14:0], sq_ge};
            end
            S_BETA: begin
                if (r_idx == 5'd1)
                    r_cut <= (cut_sum[24:16] != '0) ? 16'hFFFF : cut_sum[15:0];
            end
            S_NUM: begin
                if (r_idx == 5'd1) r_num <= mul_p[34:0];
            end
            S_DEN: begin
                r_den <= {1'b0, r_num} + {2'b00, freq, 24'd0};
            end
            S_DINIT: begin
                r_drem <= {1'b0, numer[51:17]};
                r_nlo  <= numer[16:0];
                r_quot <= '0;
            end
            S_DIV: begin
                r_drem <= dv_ge ? 36'(dv_sh - {1'b0, r_den}) : dv_sh[35:0];
                r_nlo  <= r_nlo << 1;
                r_quot <= {r_quot[15:0], dv_ge};
            end
            S_BLEND: begin
                if (r_idx[0]) begin
                    for (int i = 0; i < NCH - 1; i++) r_q[i] <= r_q[i+1];
                    r_q[NCH-1] <= r_q[0];
                end
            end
            S_OUT: begin
                if (out_load) begin
                    for (int i = 0; i < NCH; i++) r_out[i] <= r_sq[i];
                end
            end
            default: ;
        endcase
    end

    // ports
    assign m_axis_tvalid = r_ovld;
    always_comb begin
        m_axis_tdata = '0;
        for (int i = 0; i < NCH; i++)
            m_axis_tdata[i*COMP_BITS +: COMP_BITS] = r_out[i];
    end

    assign pready = 1'b1;
    always_comb begin
        unique case (paddr[3:2])
            oeqs_pkg::REG_SAMPLE_RATE: prdata = {22'd0, r_rate_hz};
            oeqs_pkg::REG_MIN_CUTOFF:  prdata = {16'd0, r_min_cut};
            oeqs_pkg::REG_BETA_GAIN:   prdata = {16'd0, r_beta};
            default:                   prdata = '0;
        endcase
    end

    // checks
    `OEQS_ASSERT_NEXT(a_out_drains, i_clk, i_rst_n, m_acc && !out_load, !m_axis_tvalid)
    `OEQS_ASSERT_NEXT(a_out_loads, i_clk, i_rst_n, out_load, m_axis_tvalid)
    `OEQS_ASSERT_NOW(a_div_rem, i_clk, i_rst_n, r_state == S_DIV, r_drem < r_den)
    `OEQS_ASSERT_NEXT(a_primed_holds, i_clk, i_rst_n, r_primed, r_primed)
    `OEQS_ASSERT_NEXT(a_accept_starts, i_clk, i_rst_n, s_acc, (r_state == S_DIST) && !s_axis_tready)

endmodule
